// File: hw/rtl/lvfs_pkg.sv
// Shared types and constants for the LED volume falloff shader.
// No dependencies; every other file in hw/rtl imports this package.
package lvfs_pkg;

   localparam int COORD_W  = 8;
   localparam int RADIUS_W = 12;
   localparam int LEVEL_W  = 8;
   localparam int STRIP_W  = 4;
   localparam int PIXEL_W  = 8;

   // inside the box every axis distance is below 256
   localparam int DIFF_W   = 8;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int SQ_IN_W  = SUM_W + 8;
   localparam int ROOT_W   = SQ_IN_W / 2;
   localparam int NUM_W    = LEVEL_W + RADIUS_W;
   localparam int QUOT_W   = 8;
   localparam int BOX_W    = (COORD_W + 4 > RADIUS_W) ? COORD_W + 4 : RADIUS_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_RADIUS   = 3'd3,
      REG_RED      = 3'd4,
      REG_GREEN    = 3'd5,
      REG_BLUE     = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] led_x;
      logic [COORD_W-1:0] led_y;
      logic [COORD_W-1:0] led_z;
      logic [STRIP_W-1:0] strip_number;
      logic [PIXEL_W-1:0] pixel_number;
   } req_word_type;

   typedef struct packed {
      logic               write_pixel;
      logic [STRIP_W-1:0] strip_out;
      logic [PIXEL_W-1:0] pixel_out;
      logic [LEVEL_W-1:0] red_out;
      logic [LEVEL_W-1:0] green_out;
      logic [LEVEL_W-1:0] blue_out;
   } rsp_word_type;

   typedef struct packed {
      logic [COORD_W-1:0]  center_x;
      logic [COORD_W-1:0]  center_y;
      logic [COORD_W-1:0]  center_z;
      logic [RADIUS_W-1:0] radius_q4;
      logic [LEVEL_W-1:0]  red_level;
      logic [LEVEL_W-1:0]  green_level;
      logic [LEVEL_W-1:0]  blue_level;
   } cfg_type;

   // carried alongside the math through the back end
   typedef struct packed {
      logic               in_box;
      logic [STRIP_W-1:0] strip;
      logic [PIXEL_W-1:0] pixel;
   } tag_type;

   typedef struct packed {
      tag_type            tag;
      logic [SUM_W-1:0]   dist_sq;
   } cls_word_type;

endpackage

// File: hw/rtl/lvfs_front.sv
// Front end: box test and squared distance for one incoming word.
// Depends on lvfs_pkg.
module lvfs_front (
   input  lvfs_pkg::req_word_type req_word,
   input  lvfs_pkg::cfg_type      cfg,
   output lvfs_pkg::cls_word_type cls_word
);
   import lvfs_pkg::*;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic box_ok(input logic [COORD_W-1:0] d,
                                   input logic [RADIUS_W-1:0] r);
      logic [BOX_W-1:0] d16;
      logic [BOX_W-1:0] rx;
      d16 = BOX_W'({d, 4'b0000});
      rx  = BOX_W'(r);
      return d16 < rx;
   endfunction

   logic [COORD_W-1:0] dx, dy, dz;
   logic [DIFF_W-1:0]  ax, ay, az;
   logic [SQ_W-1:0]    sx, sy, sz;

   always_comb begin
      dx = abs_diff(req_word.led_x, cfg.center_x);
      dy = abs_diff(req_word.led_y, cfg.center_y);
      dz = abs_diff(req_word.led_z, cfg.center_z);
      // only meaningful when inside, where every diff fits DIFF_W
      ax = DIFF_W'(dx);
      ay = DIFF_W'(dy);
      az = DIFF_W'(dz);
      sx = SQ_W'(ax) * SQ_W'(ax);
      sy = SQ_W'(ay) * SQ_W'(ay);
      sz = SQ_W'(az) * SQ_W'(az);
      cls_word.tag.in_box = box_ok(dx, cfg.radius_q4) && box_ok(dy, cfg.radius_q4)
                            && box_ok(dz, cfg.radius_q4);
      cls_word.tag.strip  = req_word.strip_number;
      cls_word.tag.pixel  = req_word.pixel_number;
      cls_word.dist_sq    = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);
   end

endmodule

// File: hw/rtl/lvfs_queue.sv
// Small FIFO between front and back ends.
// Depends on lvfs_pkg.
module lvfs_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lvfs_pkg::cls_word_type push_word,
   input  logic                   pop,
   output lvfs_pkg::cls_word_type pop_word,
   output logic                   full,
   output logic                   empty
);
   import lvfs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_word_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: hw/rtl/lvfs_back.sv
// Back end: pipelined square root, falloff multiply, pipelined divide, output register.
// Depends on lvfs_pkg.
module lvfs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lvfs_pkg::cfg_type      cfg,
   input  lvfs_pkg::cls_word_type q_word,
   input  logic                   q_valid,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lvfs_pkg::rsp_word_type rsp_word
);
   import lvfs_pkg::*;

   localparam int DV_W = NUM_W + 1;

   logic adv;

   // square root stages
   logic               sq_vld_ff  [ROOT_W+1];
   tag_type            sq_tag_ff  [ROOT_W+1];
   logic [SQ_IN_W-1:0] sq_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]  sq_root_ff [ROOT_W+1];
   logic [SQ_IN_W-1:0] sq_rem_in  [ROOT_W];
   logic [ROOT_W-1:0]  sq_root_in [ROOT_W];

   // divide stages, one lane per color
   logic               dv_vld_ff  [QUOT_W+1];
   tag_type            dv_tag_ff  [QUOT_W+1];
   logic [NUM_W-1:0]   dv_rem_ff  [3][QUOT_W+1];
   logic [QUOT_W-1:0]  dv_quot_ff [3][QUOT_W+1];
   logic [NUM_W-1:0]   dv_rem_in  [3][QUOT_W];
   logic [QUOT_W-1:0]  dv_quot_in [3][QUOT_W];

   logic [LEVEL_W-1:0]  level [3];
   logic                below;
   logic [RADIUS_W-1:0] span;
   logic [NUM_W-1:0]    num_in [3];

   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_vld_ff;

   assign adv       = !rsp_vld_ff || rsp_ready;
   assign q_pop     = adv && q_valid;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

   assign level[0] = cfg.red_level;
   assign level[1] = cfg.green_level;
   assign level[2] = cfg.blue_level;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ROOT_W; i++) sq_vld_ff[i] <= 1'b0;
         for (int i = 0; i <= QUOT_W; i++) dv_vld_ff[i] <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= q_valid;
         for (int i = 1; i <= ROOT_W; i++) sq_vld_ff[i] <= sq_vld_ff[i-1];
         dv_vld_ff[0] <= sq_vld_ff[ROOT_W];
         for (int i = 1; i <= QUOT_W; i++) dv_vld_ff[i] <= dv_vld_ff[i-1];
         rsp_vld_ff <= dv_vld_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_tag_ff[0]  <= q_word.tag;
         sq_rem_ff[0]  <= {q_word.dist_sq, 8'b0};
         sq_root_ff[0] <= '0;
      end
   end

   // one root bit per stage: try root + 2^b against the remainder
   for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
      localparam int B = ROOT_W - 1 - s;
      logic [SQ_IN_W:0] term;
      logic             ge;
      always_comb begin
         term = ((SQ_IN_W+1)'(sq_root_ff[s]) << (B + 1)) + ((SQ_IN_W+1)'(1) << (2 * B));
         ge   = {1'b0, sq_rem_ff[s]} >= term;
         sq_rem_in[s]  = ge ? sq_rem_ff[s] - term[SQ_IN_W-1:0] : sq_rem_ff[s];
         sq_root_in[s] = ge ? (sq_root_ff[s] | (ROOT_W'(1) << B)) : sq_root_ff[s];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_tag_ff[s+1]  <= sq_tag_ff[s];
            sq_rem_ff[s+1]  <= sq_rem_in[s];
            sq_root_ff[s+1] <= sq_root_in[s];
         end
      end
   end

   // falloff numerator: level * (radius - dist), zero outside the sphere
   always_comb begin
      below = ROOT_W'(cfg.radius_q4) > sq_root_ff[ROOT_W];
      span  = cfg.radius_q4 - sq_root_ff[ROOT_W][RADIUS_W-1:0];
      for (int c = 0; c < 3; c++) begin
         num_in[c] = below ? NUM_W'(level[c]) * NUM_W'(span) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_tag_ff[0] <= sq_tag_ff[ROOT_W];
         for (int c = 0; c < 3; c++) begin
            dv_rem_ff[c][0]  <= num_in[c];
            dv_quot_ff[c][0] <= '0;
         end
      end
   end

   // one quotient bit per stage, restoring
   for (genvar d = 0; d < QUOT_W; d++) begin : g_div
      localparam int B = QUOT_W - 1 - d;
      for (genvar c = 0; c < 3; c++) begin : g_lane
         logic [DV_W-1:0] shifted;
         logic            ge;
         always_comb begin
            shifted = DV_W'(cfg.radius_q4) << B;
            ge      = DV_W'(dv_rem_ff[c][d]) >= shifted;
            dv_rem_in[c][d]  = ge ? dv_rem_ff[c][d] - shifted[NUM_W-1:0] : dv_rem_ff[c][d];
            dv_quot_in[c][d] = ge ? (dv_quot_ff[c][d] | (QUOT_W'(1) << B))
                                  : dv_quot_ff[c][d];
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[c][d+1]  <= dv_rem_in[c][d];
               dv_quot_ff[c][d+1] <= dv_quot_in[c][d];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_tag_ff[d+1] <= dv_tag_ff[d];
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (dv_tag_ff[QUOT_W].in_box) begin
         rsp_in.write_pixel = 1'b1;
         rsp_in.strip_out   = dv_tag_ff[QUOT_W].strip;
         rsp_in.pixel_out   = dv_tag_ff[QUOT_W].pixel;
         rsp_in.red_out     = dv_quot_ff[0][QUOT_W];
         rsp_in.green_out   = dv_quot_ff[1][QUOT_W];
         rsp_in.blue_out    = dv_quot_ff[2][QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.write_pixel) |-> (rsp_ff == '0))
      else $error("no-write word carries data");
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ready) |=> ($stable(dv_vld_ff[QUOT_W]) && $stable(rsp_ff)))
      else $error("pipeline moved during output stall");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_vld_ff && !sq_vld_ff[0]))
      else $error("pipeline valid after reset");
`endif

endmodule

// File: hw/rtl/led_volume_falloff_shader.sv
// Top level of the LED volume falloff shader: CSR block, front end, queue, back end.
// Depends on lvfs_pkg, lvfs_front, lvfs_queue, lvfs_back.
//
//   channel  direction  handshake               word
//   req      in         req_valid / req_ready   req_word  (lvfs_pkg::req_word_type)
//   rsp      out        rsp_valid / rsp_ready   rsp_word  (lvfs_pkg::rsp_word_type)
//   csr      in/out     psel/penable/pready     paddr, pwdata, prdata (APB style)
//
// One word per cycle sustained while rsp is not stalled. The path from accept to rsp_valid runs through
// the queue, 13 root stages, 1 multiply stage, 8 divide stages and the output register.
// Synchronous active-high reset empties the queue and pipeline; CSRs return to
// centre 0,0,0, radius 10.0 (160 in Q8.4), levels 0.
// A stall on rsp freezes the back pipeline; the queue (QUEUE_DEPTH words) keeps
// req_ready high until it fills.
module led_volume_falloff_shader #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lvfs_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lvfs_pkg::rsp_word_type              rsp_word,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lvfs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lvfs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lvfs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import lvfs_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          csr_write;

   cls_word_type  cls_word;
   cls_word_type  q_word;
   logic          q_full, q_empty, q_pop, q_push;

   // ---------------- CSR block ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = reg_index_type'(paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_CENTER_X: cfg_in.center_x    = pwdata[COORD_W-1:0];
            REG_CENTER_Y: cfg_in.center_y    = pwdata[COORD_W-1:0];
            REG_CENTER_Z: cfg_in.center_z    = pwdata[COORD_W-1:0];
            REG_RADIUS:   cfg_in.radius_q4   = pwdata[RADIUS_W-1:0];
            REG_RED:      cfg_in.red_level   = pwdata[LEVEL_W-1:0];
            REG_GREEN:    cfg_in.green_level = pwdata[LEVEL_W-1:0];
            REG_BLUE:     cfg_in.blue_level  = pwdata[LEVEL_W-1:0];
            default:      cfg_in = cfg_ff;  // unmapped: ignore
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{center_x: '0, center_y: '0, center_z: '0,
                     radius_q4: RADIUS_W'(160),
                     red_level: '0, green_level: '0, blue_level: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CENTER_X: prdata = CSR_DATA_W'(cfg_ff.center_x);
         REG_CENTER_Y: prdata = CSR_DATA_W'(cfg_ff.center_y);
         REG_CENTER_Z: prdata = CSR_DATA_W'(cfg_ff.center_z);
         REG_RADIUS:   prdata = CSR_DATA_W'(cfg_ff.radius_q4);
         REG_RED:      prdata = CSR_DATA_W'(cfg_ff.red_level);
         REG_GREEN:    prdata = CSR_DATA_W'(cfg_ff.green_level);
         REG_BLUE:     prdata = CSR_DATA_W'(cfg_ff.blue_level);
         default:      prdata = '0;
      endcase
   end

   // ---------------- front: classify and enqueue ----------------
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   lvfs_front u_front (
      .req_word (req_word),
      .cfg      (cfg_ff),
      .cls_word (cls_word)
   );

   lvfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (cls_word),
      .pop       (q_pop),
      .pop_word  (q_word),
      .full      (q_full),
      .empty     (q_empty)
   );

   // ---------------- back: root, falloff, divide ----------------
   lvfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_word    (q_word),
      .q_valid   (!q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// File: tb/lvfs_checker.sv
// Watches the req and rsp channels of the LED volume falloff shader, predicts each rsp word
// and compares it. Depends on lvfs_pkg; the CSR values are mirrored from the APB writes.
module lvfs_checker
   import lvfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_word_type          req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    lit_count,
   output int                    rsp_count
);

   cfg_type      shade_cfg;
   rsp_word_type pixel_queue[$];

   function automatic logic [31:0] root_floor(logic [31:0] v);
      logic [31:0] r;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
         if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= v)
            r = r | (32'd1 << b);
      end
      return r;
   endfunction

   function automatic rsp_word_type shade_pixel(req_word_type w);
      rsp_word_type o;
      int unsigned dx, dy, dz, r, dist_q4;
      o = '0;
      r  = 32'(shade_cfg.radius_q4);
      dx = (w.led_x >= shade_cfg.center_x) ? 32'(w.led_x) - 32'(shade_cfg.center_x)
                                           : 32'(shade_cfg.center_x) - 32'(w.led_x);
      dy = (w.led_y >= shade_cfg.center_y) ? 32'(w.led_y) - 32'(shade_cfg.center_y)
                                           : 32'(shade_cfg.center_y) - 32'(w.led_y);
      dz = (w.led_z >= shade_cfg.center_z) ? 32'(w.led_z) - 32'(shade_cfg.center_z)
                                           : 32'(shade_cfg.center_z) - 32'(w.led_z);
      if (dx * 16 < r && dy * 16 < r && dz * 16 < r) begin
         dist_q4 = root_floor((dx * dx + dy * dy + dz * dz) * 256);
         o.write_pixel = 1'b1;
         o.strip_out   = w.strip_number;
         o.pixel_out   = w.pixel_number;
         if (dist_q4 < r) begin
            o.red_out   = 8'((32'(shade_cfg.red_level) * (r - dist_q4)) / r);
            o.green_out = 8'((32'(shade_cfg.green_level) * (r - dist_q4)) / r);
            o.blue_out  = 8'((32'(shade_cfg.blue_level) * (r - dist_q4)) / r);
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         shade_cfg <= '{8'd0, 8'd0, 8'd0, 12'd160, 8'd0, 8'd0, 8'd0};
         pixel_queue.delete();
         fail_count = 0;
         lit_count  <= 0;
         rsp_count  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (pixel_queue.size() == 0)
               report_mismatch("unexpected word", 1, 0);
            else begin
               want = pixel_queue.pop_front();
               if (want.write_pixel) lit_count <= lit_count + 1;
               if (rsp_word.write_pixel !== want.write_pixel)
                  report_mismatch("write_pixel", int'(rsp_word.write_pixel),
                                  int'(want.write_pixel));
               if (rsp_word.strip_out !== want.strip_out)
                  report_mismatch("strip_out", int'(rsp_word.strip_out),
                                  int'(want.strip_out));
               if (rsp_word.pixel_out !== want.pixel_out)
                  report_mismatch("pixel_out", int'(rsp_word.pixel_out),
                                  int'(want.pixel_out));
               if (rsp_word.red_out !== want.red_out)
                  report_mismatch("red_out", int'(rsp_word.red_out), int'(want.red_out));
               if (rsp_word.green_out !== want.green_out)
                  report_mismatch("green_out", int'(rsp_word.green_out),
                                  int'(want.green_out));
               if (rsp_word.blue_out !== want.blue_out)
                  report_mismatch("blue_out", int'(rsp_word.blue_out), int'(want.blue_out));
            end
         end
         // config writes must only land while idle (the checker does not enforce it), so prediction order is safe
         if (req_valid && req_ready)
            pixel_queue.push_back(shade_pixel(req_word));
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_CENTER_X: shade_cfg.center_x    <= pwdata[7:0];
               REG_CENTER_Y: shade_cfg.center_y    <= pwdata[7:0];
               REG_CENTER_Z: shade_cfg.center_z    <= pwdata[7:0];
               REG_RADIUS:   shade_cfg.radius_q4   <= pwdata[11:0];
               REG_RED:      shade_cfg.red_level   <= pwdata[7:0];
               REG_GREEN:    shade_cfg.green_level <= pwdata[7:0];
               REG_BLUE:     shade_cfg.blue_level  <= pwdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_comb pending_count = pixel_queue.size();

endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the LED volume falloff shader testbench.
// Depends on lvfs_pkg, led_volume_falloff_shader and lvfs_checker.
module tb_top;
   import lvfs_pkg::*;

   localparam int LATENCY   = 24;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_LEN  = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_valid, req_ready, rsp_valid, rsp_ready;
   req_word_type          req_word;
   rsp_word_type          rsp_word;
   logic                  psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;
   int                    fail_count, pending_count, lit_count, rsp_count;

   // idle odds out of 100 per phase; a long hold-off of the receiver on request
   int  send_idle_pct, recv_idle_pct;
   int  hold_cycles;
   int  hold_reqs;
   int  hold_seen;
   int  quiet_cycles;
   int  word_count;
   logic [7:0] cx, cy, cz;
   logic [11:0] rad;

   led_volume_falloff_shader i_dut (.*);

   lvfs_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stalls, plus a long counted hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= 0;
         hold_seen   <= 0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen   <= hold_reqs;
         hold_cycles <= HOLD_LEN;
         rsp_ready   <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_sphere(logic [7:0] x, logic [7:0] y, logic [7:0] z, logic [11:0] r,
                             logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
      cx = x; cy = y; cz = z; rad = r;
      csr_write(REG_CENTER_X, {$urandom} & 32'hffff_ff00 | 32'(x));  // upper bits are masked off
      csr_write(REG_CENTER_Y, 32'(y));
      csr_write(REG_CENTER_Z, 32'(z));
      csr_write(REG_RADIUS, 32'(r));
      csr_write(REG_RED, 32'(red));
      csr_write(REG_GREEN, 32'(grn));
      csr_write(REG_BLUE, 32'(blu));
   endtask

   // one word, held until accepted; the sender may idle before it
   task automatic send_led(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                           logic [3:0] strip, logic [7:0] pixel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{x, y, z, strip, pixel};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      word_count++;
   endtask

   // wait for the pipe to empty before touching the CSRs
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // most words near the sphere so the falloff math gets exercised
   task automatic send_near;
      int span;
      span = int'(rad >> 4) + 2;
      if ($urandom_range(3) == 0)
         send_led(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
      else
         send_led(8'(int'(cx) + int'($urandom_range(2 * span)) - span),
                  8'(int'(cy) + int'($urandom_range(2 * span)) - span),
                  8'(int'(cz) + int'($urandom_range(2 * span)) - span),
                  4'($urandom), 8'($urandom));
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      send_idle_pct = 12; recv_idle_pct = 46;
      hold_reqs = 0;
      word_count = 0;
      cx = 0; cy = 0; cz = 0; rad = 160;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: levels 0, so only the box test and pass-through show
      send_led(3, 4, 5, 4'hf, 8'hff);
      send_led(255, 255, 255, 0, 0);
      drain;

      // directed: centre, axis edges of the box, corners, coordinate extremes
      set_sphere(128, 128, 128, 12'd160, 8'hff, 8'h80, 8'h01);
      send_led(128, 128, 128, 4'ha, 8'h55);
      send_led(137, 128, 128, 4'h5, 8'haa);  // just inside on x
      send_led(138, 128, 128, 4'h1, 8'h01);  // on the edge: no write
      send_led(128, 119, 128, 4'h2, 8'h02);
      send_led(128, 128, 118, 4'h3, 8'h03);
      send_led(137, 137, 137, 4'h4, 8'h04);  // box corner, beyond the sphere: colour 0
      send_led(0, 0, 0, 0, 0);
      send_led(255, 255, 255, 4'hf, 8'hff);
      drain;
      // largest radius and full levels: everything inside the box, even the far corners
      set_sphere(0, 255, 0, 12'd4095, 8'hff, 8'hff, 8'hff);
      send_led(255, 0, 255, 4'hf, 8'hff);
      send_led(0, 255, 0, 0, 0);
      send_led(128, 128, 128, 4'h7, 8'h80);
      drain;
      // smallest radius: only the centre itself passes
      set_sphere(255, 0, 255, 12'd1, 8'hff, 8'hff, 8'hff);
      send_led(255, 0, 255, 4'h9, 8'h99);
      send_led(254, 0, 255, 4'h9, 8'h98);
      drain;
      // zero radius: the box test never passes, so nothing can be written
      set_sphere(50, 50, 50, 12'd0, 8'hff, 8'hff, 8'hff);
      send_led(50, 50, 50, 4'h6, 8'h66);
      drain;

      // random phases, each with a fresh sphere; the idle odds change at phases 3 and 6
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin send_idle_pct = 46; recv_idle_pct = 12; end
         if (ph == 6) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         set_sphere(8'($urandom), 8'($urandom), 8'($urandom),
                    (ph % 4 == 0) ? 12'd4095 : 12'($urandom_range(4095, 1)),
                    8'($urandom), 8'($urandom), 8'($urandom));
         for (int n = 0; n < 250; n++) begin
            if (ph == 6 && n == 50) hold_reqs++;  // long back-pressure
            send_near;
         end
         drain;
      end

      wait (pending_count == 0);
      repeat (LATENCY + 4) @(posedge clock);
      $display("covered %0d words, %0d responses, %0d pixel writes", word_count, rsp_count,
               lit_count);
      $display("sphere settings from zero to full radius, stalls on both sides");
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
